// ----- src/gtem_pkg.sv -----
// ----------------------------------------------------------------------------
// Gradient threshold edge map: shared package
// Widths, register indexes and the result record used by the edge map block.
// ----------------------------------------------------------------------------
package gtem_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 16;
   localparam int PIX_W       = 8;
   localparam int THR_W       = 8;
   localparam int FW_W        = COL_W + 1;
   localparam int FH_W        = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = RSP_PTR_W + 1;
   localparam int PUSH_SLOTS  = 3;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(32);
   localparam logic [FW_W-1:0]  WIDTH_RESET     = FW_W'(640);
   localparam logic [FH_W-1:0]  HEIGHT_RESET    = FH_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EDGE_THRESHOLD = 2'd0,
      CSR_FRAME_WIDTH    = 2'd1,
      CSR_FRAME_HEIGHT   = 2'd2
   } gtem_csr_type;

   typedef struct packed {
      logic             edge_bit;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             frame_done;
   } gtem_result_type;

   typedef struct packed {
      logic [1:0]                       count;
      gtem_result_type [PUSH_SLOTS-1:0] slot;
   } gtem_push_type;

endpackage

// ----- src/gtem_ram.sv -----
// ----------------------------------------------------------------------------
// Gradient threshold edge map: generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gtem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/gtem_rsp_fifo.sv -----
// ----------------------------------------------------------------------------
// Gradient threshold edge map: result queue
// Takes up to three results per cycle and hands them out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module gtem_rsp_fifo
   import gtem_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  gtem_push_type        push,
   input  logic                 pop,
   output logic                 out_valid,
   output gtem_result_type      out_data,
   output logic [RSP_CNT_W-1:0] count
);

   gtem_result_type        entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop_ok;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop_ok    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop_ok);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PUSH_SLOTS; k++) begin
         if (k < int'(push.count)) begin
            entry_ff[wr_ptr_ff + RSP_PTR_W'(k)] <= push.slot[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/gradient_threshold_edge_map_top.sv -----
// ----------------------------------------------------------------------------
// Gradient threshold edge map: top level
// Marks each pixel of a raster-order gray frame as edge or background.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle while req_stall is low and
// classifies it against its right neighbour and the pixel below, using a
// one-row line buffer held in two RAMs of MAX_WIDTH entries (pixels and
// right-hand verdicts). An item stays in the input register while the line
// buffer is read, and its results enter a small result queue at the next edge.
// The first row gives no results unless it is also the last; on the other
// rows but the last each item gives one result and the block runs at one item
// per cycle while rsp_stall is low. On the last row each item but the first
// gives two results (three for the final pixel); the single port sets the pace.
// ----------------------------------------------------------------------------
module gradient_threshold_edge_map_top
   import gtem_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_gray_pixel,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_edge_bit,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic                  rsp_frame_done
);

   logic [THR_W-1:0] threshold_ff;
   logic [FW_W-1:0]  width_ff;
   logic [FH_W-1:0]  height_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [FW_W-1:0]  width_eff;
   logic [FH_W-1:0]  height_eff;
   logic             last_col, last_row;
   logic             req_accept;

   logic             st_valid_ff;
   logic [PIX_W-1:0] st_pixel_ff;
   logic [COL_W-1:0] st_col_ff;
   logic [ROW_W-1:0] st_row_ff;
   logic             st_last_col_ff, st_last_row_ff;
   logic [PIX_W-1:0] left_pixel_ff;

   logic             pix_byp_ff, flag_byp_ff;
   logic [PIX_W-1:0] pix_byp_data_ff;
   logic             flag_byp_data_ff;
   logic [PIX_W-1:0] pix_ram_q, above_pixel;
   logic             flag_ram_q, above_flag;

   logic             pix_wr_en, flag_wr_en;
   logic [COL_W-1:0] flag_wr_addr;

   logic             below_edge, right_edge;
   gtem_result_type  res_above, res_left, res_final;
   logic             res_above_v, res_left_v, res_final_v;
   gtem_push_type    push;

   gtem_result_type        rsp_head;
   logic [RSP_CNT_W-1:0]   rsp_count;

   function automatic logic exceeds(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                    input logic [THR_W-1:0] thr);
      logic [PIX_W-1:0] diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff > thr;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (gtem_csr_type'(csr_index))
            CSR_EDGE_THRESHOLD: begin
               threshold_ff <= csr_wr_data[THR_W-1:0];
            end
            CSR_FRAME_WIDTH: begin
               width_ff <= csr_wr_data[FW_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               height_ff <= csr_wr_data[FH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Position of the next pixel and the frame boundaries.
   always_comb begin
      if (width_ff == '0) begin
         width_eff = FW_W'(1);
      end else if (width_ff > FW_W'(MAX_WIDTH)) begin
         width_eff = FW_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff == '0) ? FH_W'(1) : height_ff;
      last_col   = (FW_W'(col_ff) + FW_W'(1)) >= width_eff;
      last_row   = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, height_eff};

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   assign req_stall  = reset || ((rsp_count + RSP_CNT_W'(push.count)) >
                                 RSP_CNT_W'(RSP_DEPTH - PUSH_SLOTS));
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= req_accept;
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         st_pixel_ff    <= req_gray_pixel;
         st_col_ff      <= col_ff;
         st_row_ff      <= row_ff;
         st_last_col_ff <= last_col;
         st_last_row_ff <= last_row;
      end
   end

   // Line buffer; a write to the address being read is forwarded.
   assign pix_wr_en    = st_valid_ff;
   assign flag_wr_en   = st_valid_ff && (st_col_ff != '0);
   assign flag_wr_addr = st_col_ff - COL_W'(1);

   gtem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr (st_col_ff),
      .wr_data (st_pixel_ff),
      .rd_addr (col_ff),
      .rd_data (pix_ram_q)
   );

   gtem_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_wr_en),
      .wr_addr (flag_wr_addr),
      .wr_data (right_edge),
      .rd_addr (col_ff),
      .rd_data (flag_ram_q)
   );

   always_ff @(posedge clock) begin
      pix_byp_ff       <= pix_wr_en && (st_col_ff == col_ff);
      pix_byp_data_ff  <= st_pixel_ff;
      flag_byp_ff      <= flag_wr_en && (flag_wr_addr == col_ff);
      flag_byp_data_ff <= right_edge;
      if (reset) begin
         left_pixel_ff <= '0;
      end else if (st_valid_ff) begin
         left_pixel_ff <= st_pixel_ff;
      end
   end

   assign above_pixel = pix_byp_ff ? pix_byp_data_ff : pix_ram_q;
   assign above_flag  = flag_byp_ff ? flag_byp_data_ff : flag_ram_q;

   // Classification of the pixels completed by this item.
   always_comb begin
      logic [1:0] n;
      n          = '0;
      below_edge = exceeds(above_pixel, st_pixel_ff, threshold_ff) ||
                   (!st_last_col_ff && above_flag);
      right_edge = (st_col_ff != '0) && exceeds(left_pixel_ff, st_pixel_ff, threshold_ff);

      res_above_v          = st_valid_ff && (st_row_ff != '0);
      res_above.edge_bit   = !below_edge;
      res_above.out_row    = st_row_ff - ROW_W'(1);
      res_above.out_col    = st_col_ff;
      res_above.frame_done = 1'b0;

      res_left_v           = st_valid_ff && (st_col_ff != '0) && st_last_row_ff;
      res_left.edge_bit    = !right_edge;
      res_left.out_row     = st_row_ff;
      res_left.out_col     = st_col_ff - COL_W'(1);
      res_left.frame_done  = 1'b0;

      res_final_v          = st_valid_ff && st_last_row_ff && st_last_col_ff;
      res_final.edge_bit   = 1'b1;
      res_final.out_row    = st_row_ff;
      res_final.out_col    = st_col_ff;
      res_final.frame_done = 1'b1;

      push = '0;
      if (res_above_v) begin
         push.slot[n] = res_above;
         n            = n + 2'd1;
      end
      if (res_left_v) begin
         push.slot[n] = res_left;
         n            = n + 2'd1;
      end
      if (res_final_v) begin
         push.slot[n] = res_final;
         n            = n + 2'd1;
      end
      push.count = n;
   end

   gtem_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_head),
      .count     (rsp_count)
   );

   assign rsp_edge_bit   = rsp_head.edge_bit;
   assign rsp_out_row    = rsp_head.out_row;
   assign rsp_out_col    = rsp_head.out_col;
   assign rsp_frame_done = rsp_head.frame_done;

   a_queue_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_count <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue holds more items than its depth");

   a_done_is_background: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_edge_bit)
      else $error("final item of a frame is not marked background");

   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      st_valid_ff && st_last_col_ff && st_last_row_ff |-> (col_ff == '0) && (row_ff == '0))
      else $error("position did not return to the frame start");

endmodule
